@@ hdl/sorted_region_table_lookup_unit_macros.svh @@
// assertion macros used by the region table lookup unit
`ifndef SORTED_REGION_TABLE_LOOKUP_UNIT_MACROS_SVH
`define SORTED_REGION_TABLE_LOOKUP_UNIT_MACROS_SVH

// condition implies consequence in the same cycle
`define SRTL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define SRTL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/srtl_pkg.sv @@
// package with beat types, table entry type and command and status codes
package srtl_pkg;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_OVERLAP   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [38:0] range_start;
    logic [39:0] range_end;
    logic [2:0]  region_flags_in;
    logic [38:0] lookup_addr;
  } srtl_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [38:0] region_start;
    logic [39:0] region_end;
    logic [2:0]  region_flags;
    logic        cache_hit;
    logic [6:0]  region_count;
  } srtl_out_t;

  typedef struct packed {
    logic [38:0] reg_start;
    logic [39:0] reg_end;
    logic [2:0]  reg_flags;
  } srtl_entry_t;

endpackage

@@ hdl/srtl_ram.sv @@
// region table memory: one write port, one read port with registered data
module srtl_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  srtl_pkg::srtl_entry_t wdata,
  input  logic [AW-1:0]        raddr,
  output srtl_pkg::srtl_entry_t rdata
);
  import srtl_pkg::*;

  srtl_entry_t mem [DEPTH];
  srtl_entry_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/sorted_region_table_lookup_unit.sv @@
// sorted region table: one command at a time, results via an output register
// clear, unused and empty-range commands go straight to the result; lookup probes the last-hit
// entry first, else scans from the lowest start, and reports not found at once on an empty table;
// insert reads entries to find its place, shifts the entries above it up and writes, or rejects;
// a new command is taken only after the last result is loaded, which waits while out_ready is low
// synchronous rst_n clears count, last hit and handshake state; table memory is not cleared
module sorted_region_table_lookup_unit #(
  parameter int MAX_REGIONS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  srtl_pkg::srtl_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output srtl_pkg::srtl_out_t out_data
);
  import srtl_pkg::*;
  `include "sorted_region_table_lookup_unit_macros.svh"

  localparam int IW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INS_RD   = 4'd1;
  localparam logic [3:0] S_INS_CHK  = 4'd2;
  localparam logic [3:0] S_INS_EVAL = 4'd3;
  localparam logic [3:0] S_SH_RD    = 4'd4;
  localparam logic [3:0] S_SH_WR    = 4'd5;
  localparam logic [3:0] S_INS_WR   = 4'd6;
  localparam logic [3:0] S_LK_CRD   = 4'd7;
  localparam logic [3:0] S_LK_CCHK  = 4'd8;
  localparam logic [3:0] S_LK_RD    = 4'd9;
  localparam logic [3:0] S_LK_CHK   = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0]  state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic        lh_valid_r, lh_valid_nxt;
  logic [IW-1:0] lh_idx_r, lh_idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  srtl_out_t   out_data_r, out_data_nxt;
  srtl_in_t    req_r, req_nxt;
  srtl_out_t   res_r, res_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] sh_r, sh_nxt;
  logic [39:0] prev_end_r, prev_end_nxt;
  logic        prev_valid_r, prev_valid_nxt;
  logic [38:0] next_start_r, next_start_nxt;
  logic        next_valid_r, next_valid_nxt;

  logic        mem_we;
  logic [IW-1:0] mem_waddr;
  logic [IW-1:0] mem_raddr;
  srtl_entry_t mem_wdata;
  srtl_entry_t mem_rdata;

  logic [CW-1:0] sh_dec;
  logic        idx_last;
  logic        rd_holds;
  logic        overlap;

  srtl_ram #(
    .DEPTH (MAX_REGIONS),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // helpers on the scan position and the entry just read
  assign sh_dec   = sh_r - CW'(1);
  assign idx_last = (CW'(idx_r) + CW'(1)) == count_r;
  assign rd_holds = (mem_rdata.reg_start <= req_r.lookup_addr) &&
                    ({1'b0, req_r.lookup_addr} < mem_rdata.reg_end);
  assign overlap  = (prev_valid_r && (prev_end_r > {1'b0, req_r.range_start})) ||
                    (next_valid_r && (req_r.range_end > {1'b0, next_start_r}));

  // memory port selection
  always_comb begin
    mem_raddr = idx_r;
    mem_we    = 1'b0;
    mem_waddr = sh_r[IW-1:0];
    mem_wdata = mem_rdata;
    unique case (state_r)
      S_LK_CRD: mem_raddr = lh_idx_r;
      S_SH_RD:  mem_raddr = sh_dec[IW-1:0];
      S_SH_WR:  mem_we = 1'b1;
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r[IW-1:0];
        mem_wdata = '{reg_start: req_r.range_start, reg_end: req_r.range_end,
                      reg_flags: req_r.region_flags_in};
      end
      default: mem_raddr = idx_r;
    endcase
  end

  // command sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    lh_valid_nxt   = lh_valid_r;
    lh_idx_nxt     = lh_idx_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    req_nxt        = req_r;
    res_nxt        = res_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    sh_nxt         = sh_r;
    prev_end_nxt   = prev_end_r;
    prev_valid_nxt = prev_valid_r;
    next_start_nxt = next_start_r;
    next_valid_nxt = next_valid_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt        = in_data;
          res_nxt        = '0;
          idx_nxt        = '0;
          pos_nxt        = '0;
          prev_valid_nxt = 1'b0;
          next_valid_nxt = 1'b0;
          state_nxt      = S_DONE;
          unique case (in_data.command)
            CMD_INSERT: begin
              if ({1'b0, in_data.range_start} >= in_data.range_end) begin
                res_nxt.status = ST_EMPTY;
              end else if (count_r == '0) begin
                state_nxt = S_INS_EVAL;
              end else begin
                state_nxt = S_INS_RD;
              end
            end
            CMD_LOOKUP: begin
              if (lh_valid_r && (CW'(lh_idx_r) < count_r)) begin
                state_nxt = S_LK_CRD;
              end else if (count_r == '0) begin
                res_nxt.status = ST_NOT_FOUND;
              end else begin
                state_nxt = S_LK_RD;
              end
            end
            CMD_CLEAR: begin
              count_nxt    = '0;
              lh_valid_nxt = 1'b0;
              lh_idx_nxt   = '0;
            end
            default: res_nxt.status = ST_OK;
          endcase
        end
      end

      // scan for the first entry starting above the new start
      S_INS_RD: state_nxt = S_INS_CHK;
      S_INS_CHK: begin
        if (mem_rdata.reg_start <= req_r.range_start) begin
          prev_end_nxt   = mem_rdata.reg_end;
          prev_valid_nxt = 1'b1;
          if (idx_last) begin
            pos_nxt   = count_r;
            state_nxt = S_INS_EVAL;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = S_INS_RD;
          end
        end else begin
          pos_nxt        = CW'(idx_r);
          next_start_nxt = mem_rdata.reg_start;
          next_valid_nxt = 1'b1;
          state_nxt      = S_INS_EVAL;
        end
      end

      // overlap and capacity checks
      S_INS_EVAL: begin
        sh_nxt = count_r;
        if (overlap) begin
          res_nxt.status = ST_OVERLAP;
          state_nxt      = S_DONE;
        end else if (count_r == CW'(MAX_REGIONS)) begin
          res_nxt.status = ST_FULL;
          state_nxt      = S_DONE;
        end else if (pos_r == count_r) begin
          state_nxt = S_INS_WR;
        end else begin
          state_nxt = S_SH_RD;
        end
      end

      // move entries above the insert point up by one
      S_SH_RD: state_nxt = S_SH_WR;
      S_SH_WR: begin
        sh_nxt    = sh_dec;
        state_nxt = (sh_dec == pos_r) ? S_INS_WR : S_SH_RD;
      end

      S_INS_WR: begin
        count_nxt = count_r + CW'(1);
        if (lh_valid_r && (CW'(lh_idx_r) >= pos_r)) begin
          lh_idx_nxt = lh_idx_r + IW'(1);
        end
        res_nxt.status = ST_OK;
        state_nxt      = S_DONE;
      end

      // last-hit probe
      S_LK_CRD: state_nxt = S_LK_CCHK;
      S_LK_CCHK: begin
        if (rd_holds) begin
          res_nxt.region_start = mem_rdata.reg_start;
          res_nxt.region_end   = mem_rdata.reg_end;
          res_nxt.region_flags = mem_rdata.reg_flags;
          res_nxt.cache_hit    = 1'b1;
          state_nxt            = S_DONE;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_LK_RD;
        end
      end

      // linear scan from the lowest start
      S_LK_RD: state_nxt = S_LK_CHK;
      S_LK_CHK: begin
        if (rd_holds) begin
          res_nxt.region_start = mem_rdata.reg_start;
          res_nxt.region_end   = mem_rdata.reg_end;
          res_nxt.region_flags = mem_rdata.reg_flags;
          lh_idx_nxt           = idx_r;
          lh_valid_nxt         = 1'b1;
          state_nxt            = S_DONE;
        end else if (idx_last) begin
          res_nxt.status = ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = S_LK_RD;
        end
      end

      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt              = res_r;
          out_data_nxt.region_count = 7'(count_r);
          out_valid_nxt             = 1'b1;
          state_nxt                 = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      lh_valid_r  <= 1'b0;
      lh_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      lh_valid_r  <= lh_valid_nxt;
      lh_idx_r    <= lh_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    req_r        <= req_nxt;
    res_r        <= res_nxt;
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    sh_r         <= sh_nxt;
    prev_end_r   <= prev_end_nxt;
    prev_valid_r <= prev_valid_nxt;
    next_start_r <= next_start_nxt;
    next_valid_r <= next_valid_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `SRTL_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(MAX_REGIONS), "count above table size")
  `SRTL_ASSERT_NOW(a_last_hit_in_range, lh_valid_r, CW'(lh_idx_r) < count_r, "last hit past count")
  `SRTL_ASSERT_NOW(a_scan_in_range, state_r == S_LK_CHK, CW'(idx_r) < count_r, "scan past count")
  `SRTL_ASSERT_NOW(a_shift_above_pos, state_r == S_SH_RD, sh_r > pos_r, "shift below insert point")
  `SRTL_ASSERT_NEXT(a_insert_grows, state_r == S_INS_WR, count_r == $past(count_r) + CW'(1), "insert count")

endmodule
